/* hdl/lzwc_pkg.sv */
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared dictionary entry type and fixed constants.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int CODE_W = 16;
    localparam int BYTE_W = 8;
    localparam int KEY_W  = CODE_W + 1;

    localparam logic [CODE_W-1:0] PROBE_SKIP = 16'd101;
    localparam logic [KEY_W-1:0]  KEY_SET    = 17'h08000;

    typedef struct packed {
        logic              used;
        logic [CODE_W-1:0] link;
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] suffix;
    } t_entry;

endpackage

/* hdl/lzwc_dict_mem.sv */
// ----------------------------------------------------------------------------
// LZW dictionary memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lzwc_dict_mem #(
    parameter int DEPTH = 65536
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  lzwc_pkg::t_entry        i_wr_data,
    input  logic                    i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output lzwc_pkg::t_entry        o_rd_data
);
    import lzwc_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* hdl/lzwc_hash.sv */
// ----------------------------------------------------------------------------
// LZW mid-square hash
// Two-stage pipeline: key register, then squared key register.
// ----------------------------------------------------------------------------
module lzwc_hash (
    input  logic                           i_clk,
    input  logic [lzwc_pkg::CODE_W-1:0]    i_pred,
    input  logic [lzwc_pkg::BYTE_W-1:0]    i_foll,
    output logic [lzwc_pkg::CODE_W-1:0]    o_idx
);
    import lzwc_pkg::*;

    logic [KEY_W-1:0]   r_key;
    logic [2*KEY_W-1:0] r_sq;

    always_ff @(posedge i_clk) begin
        r_key <= (KEY_W'(i_pred) + KEY_W'(i_foll)) | KEY_SET;
        r_sq  <= (2*KEY_W)'(r_key) * (2*KEY_W)'(r_key);
    end

    assign o_idx = r_sq[8 +: CODE_W];

endmodule

/* hdl/lzw_hashed_dictionary_compressor.sv */
// ----------------------------------------------------------------------------
// LZW hashed dictionary compressor
// Bytes in, 16-bit LZW codes out, 64K-entry hashed dictionary in one memory.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata             | tuser / tlast
//  i_s_*    | in  | [7:0] data_byte   | tlast: end_of_stream
//  o_m_*    | out | [15:0] code_word  | tuser[0]: final_code
//
// A byte passes the hash and address states, then the look state, which
// walks the chain, as each dictionary read gates the next. A miss adds the
// insert while its budget lasts (one write to a free hash slot, else chain
// walk, linear probe, two writes) and the root lookup. Reset and every final
// code clear all entries and insert 256 roots; no byte is accepted meanwhile.
// A stalled output holds the block; the next byte is taken once codes are out.
// ----------------------------------------------------------------------------
module lzw_hashed_dictionary_compressor #(
    parameter int          TABLE_ENTRIES = 65536,
    parameter logic [15:0] ROOT_PREFIX   = 16'hFFFF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] code_word
    output logic [0:0]  o_m_tuser    // [0] final_code
);
    import lzwc_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [CODE_W-1:0] INSERTS_INIT = CODE_W'(TABLE_ENTRIES - 256);

    typedef enum logic [3:0] {
        S_CLEAR, S_INIT, S_IDLE, S_HASH1, S_HASH2, S_ADDR, S_LOOK, S_DONE,
        S_EMIT, S_ICHK, S_ITAIL, S_IPROBE, S_IWTAIL, S_IEND
    } t_state;

    typedef enum logic [1:0] {OP_ROOT, OP_FIND, OP_INSERT, OP_INIT} t_op;

    t_state            r_state;
    t_op               r_op;
    logic [AW-1:0]     r_addr;
    logic [AW-1:0]     r_hidx;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     r_tail_addr;
    logic [AW-1:0]     r_slot;
    t_entry            r_tail_entry;
    logic [CODE_W-1:0] r_pred;
    logic [BYTE_W-1:0] r_foll;
    logic              r_last;
    logic [CODE_W-1:0] r_cur;
    logic              r_have;
    logic [CODE_W-1:0] r_inserts;
    logic [BYTE_W-1:0] r_init_b;
    logic              r_m_valid;
    logic [CODE_W-1:0] r_m_data;
    logic              r_m_final;

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    t_entry            w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    t_entry            w_rd;
    logic [CODE_W-1:0] w_hash;
    logic              w_match;
    t_entry            w_new;

    lzwc_hash u_hash (
        .i_clk  (i_clk),
        .i_pred (r_pred),
        .i_foll (r_foll),
        .o_idx  (w_hash)
    );

    lzwc_dict_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    assign w_match = w_rd.used && (w_rd.prefix == r_pred) && (w_rd.suffix == r_foll);

    always_comb begin
        w_new        = '0;
        w_new.used   = 1'b1;
        w_new.prefix = r_pred;
        w_new.suffix = r_foll;
    end

    // Memory port control; every read also moves r_addr in the clocked block.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_addr;
        w_wr_data = w_new;
        w_rd_en   = 1'b0;
        w_rd_addr = r_addr;
        case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
                w_wr_data = '0;
            end
            S_ADDR: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_hash[AW-1:0];
            end
            S_LOOK: begin
                if (!w_match && w_rd.link != '0) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rd.link[AW-1:0];
                end
            end
            S_ICHK, S_ITAIL: begin
                if (r_state == S_ICHK && !w_rd.used) begin
                    w_wr_en = 1'b1;
                end else if (w_rd.link != '0) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rd.link[AW-1:0];
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr + PROBE_SKIP[AW-1:0];
                end
            end
            S_IPROBE: begin
                if (w_rd.used) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_addr + AW'(1);
                end else begin
                    w_wr_en = 1'b1;
                end
            end
            S_IWTAIL: begin
                w_wr_en        = 1'b1;
                w_wr_addr      = r_tail_addr;
                w_wr_data      = r_tail_entry;
                w_wr_data.link = CODE_W'(r_slot);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_op       <= OP_INIT;
            r_clr_addr <= '0;
            r_have     <= 1'b0;
            r_cur      <= '0;
            r_inserts  <= INSERTS_INIT;
            r_init_b   <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (w_rd_en) begin
                r_addr <= w_rd_addr;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_pred  <= ROOT_PREFIX;
                    r_foll  <= r_init_b;
                    r_op    <= OP_INIT;
                    r_state <= S_HASH1;
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_foll  <= i_s_tdata;
                        r_last  <= i_s_tlast;
                        r_pred  <= r_have ? r_cur : ROOT_PREFIX;
                        r_op    <= r_have ? OP_FIND : OP_ROOT;
                        r_state <= S_HASH1;
                    end
                end
                S_HASH1: r_state <= S_HASH2;
                S_HASH2: r_state <= S_ADDR;
                S_ADDR: begin
                    r_hidx  <= w_hash[AW-1:0];
                    r_state <= (r_op == OP_ROOT || r_op == OP_FIND) ? S_LOOK : S_ICHK;
                end
                S_LOOK: begin
                    if (w_match) begin
                        r_cur   <= CODE_W'(r_addr);
                        r_state <= S_DONE;
                    end else if (w_rd.link == '0) begin
                        if (r_op == OP_ROOT) begin
                            r_cur   <= CODE_W'(r_hidx);
                            r_state <= S_DONE;
                        end else begin
                            r_m_valid <= 1'b1;
                            r_m_data  <= r_cur;
                            r_m_final <= 1'b0;
                            r_state   <= S_EMIT;
                        end
                    end
                end
                S_DONE: begin
                    if (r_last) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_cur;
                        r_m_final <= 1'b1;
                        r_state   <= S_EMIT;
                    end else begin
                        r_have  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (i_m_tready) begin
                        r_m_valid <= 1'b0;
                        if (r_m_final) begin
                            // End of stream: rebuild the dictionary from scratch.
                            r_have     <= 1'b0;
                            r_cur      <= '0;
                            r_inserts  <= INSERTS_INIT;
                            r_clr_addr <= '0;
                            r_state    <= S_CLEAR;
                        end else if (r_inserts != '0) begin
                            r_inserts <= r_inserts - CODE_W'(1);
                            r_op      <= OP_INSERT;
                            r_state   <= S_HASH1;
                        end else begin
                            r_pred  <= ROOT_PREFIX;
                            r_op    <= OP_ROOT;
                            r_state <= S_HASH1;
                        end
                    end
                end
                S_ICHK, S_ITAIL: begin
                    if (r_state == S_ICHK && !w_rd.used) begin
                        r_state <= S_IEND;
                    end else if (w_rd.link != '0) begin
                        r_state <= S_ITAIL;
                    end else begin
                        r_tail_addr  <= r_addr;
                        r_tail_entry <= w_rd;
                        r_state      <= S_IPROBE;
                    end
                end
                S_IPROBE: begin
                    if (!w_rd.used) begin
                        r_slot  <= r_addr;
                        r_state <= S_IWTAIL;
                    end
                end
                S_IWTAIL: r_state <= S_IEND;
                S_IEND: begin
                    if (r_op == OP_INIT) begin
                        r_init_b <= r_init_b + BYTE_W'(1);
                        r_state  <= (r_init_b == '1) ? S_IDLE : S_INIT;
                    end else begin
                        r_pred  <= ROOT_PREFIX;
                        r_op    <= OP_ROOT;
                        r_state <= S_HASH1;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_final;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("input ready while a code is pending");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_wr_en)
        else $error("dictionary written while idle");

    a_inserts_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inserts <= INSERTS_INIT)
        else $error("insert budget above its start value");

    a_busy_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_s_tready)
        else $error("ready right after reset");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tuser[0]) |=> (r_state == S_CLEAR && !r_have))
        else $error("final code did not restart the dictionary");

endmodule

/* bench/lzw_dictionary_scoreboard.sv */
// ----------------------------------------------------------------------------
// LZW compressor scoreboard
// Watches the byte and code channels, keeps its own copy of the hashed
// dictionary, predicts the codes of every accepted byte and checks them.
// ----------------------------------------------------------------------------
module lzw_dictionary_scoreboard
    import lzwc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_codes_pending,
    output int          o_codes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 65536;
    localparam int NO_HIT = -1;

    typedef struct packed {
        logic [15:0] code;
        logic        final_flag;
    } t_code;

    bit          dict_used   [ENTRIES];
    logic [15:0] dict_link   [ENTRIES];
    logic [15:0] dict_prefix [ENTRIES];
    logic [7:0]  dict_suffix [ENTRIES];
    logic [15:0] cur_code;
    logic [15:0] free_inserts;
    bit          started;
    t_code       codes_due [$];

    function automatic int hash_index(int unsigned pred, int unsigned foll);
        longint unsigned key;
        key = 64'((pred + foll) | 32'h8000);
        return int'(((key * key) >> 8) & 64'hFFFF);
    endfunction

    function automatic int lookup(int unsigned pred, int unsigned foll);
        int idx;
        idx = hash_index(pred, foll);
        for (int n = 0; n < ENTRIES; n++) begin
            if (dict_used[idx] && dict_prefix[idx] == pred && dict_suffix[idx] == foll)
                return idx;
            if (dict_link[idx] == 0)
                return NO_HIT;
            idx = int'(dict_link[idx]);
        end
        return NO_HIT;
    endfunction

    function automatic void add_string(int unsigned pred, int unsigned foll);
        int slot;
        int tail;
        slot = hash_index(pred, foll);
        if (dict_used[slot]) begin
            tail = slot;
            for (int n = 0; n < ENTRIES && dict_link[tail] != 0; n++)
                tail = int'(dict_link[tail]);
            slot = (tail + int'(PROBE_SKIP)) & 16'hFFFF;
            for (int n = 0; n < ENTRIES && dict_used[slot]; n++)
                slot = (slot + 1) & 16'hFFFF;
            if (dict_used[slot])
                return;
            dict_link[tail] = slot[15:0];
        end
        dict_used[slot]   = 1'b1;
        dict_link[slot]   = '0;
        dict_prefix[slot] = pred[15:0];
        dict_suffix[slot] = foll[7:0];
    endfunction

    function automatic logic [15:0] root_of(logic [7:0] b);
        int idx;
        idx = lookup(32'hFFFF, 32'(b));
        if (idx == NO_HIT)
            idx = hash_index(32'hFFFF, 32'(b));
        return idx[15:0];
    endfunction

    function automatic void clear_dictionary();
        for (int i = 0; i < ENTRIES; i++) begin
            dict_used[i]   = 1'b0;
            dict_link[i]   = '0;
            dict_prefix[i] = '0;
            dict_suffix[i] = '0;
        end
        cur_code     = '0;
        free_inserts = 16'(ENTRIES - 256);
        started      = 1'b0;
        for (int b = 0; b < 256; b++)
            add_string(32'hFFFF, b);
    endfunction

    function automatic void compress_byte(logic [7:0] b, logic last);
        int hit;
        if (!started) begin
            cur_code = root_of(b);
            started  = 1'b1;
        end else begin
            hit = lookup(32'(cur_code), 32'(b));
            if (hit != NO_HIT) begin
                cur_code = hit[15:0];
            end else begin
                codes_due.push_back('{code: cur_code, final_flag: 1'b0});
                if (free_inserts != 0) begin
                    add_string(32'(cur_code), 32'(b));
                    free_inserts--;
                end
                cur_code = root_of(b);
            end
        end
        if (last) begin
            codes_due.push_back('{code: cur_code, final_flag: 1'b1});
            clear_dictionary();
        end
    endfunction

    task automatic report(string what);
        $display("ERROR %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_codes_seen = 0;
        clear_dictionary();
    end

    always_comb o_codes_pending = codes_due.size();

    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                o_codes_seen++;
                if (codes_due.size() == 0) begin
                    report($sformatf("unexpected code %h", i_m_tdata));
                end else begin
                    want = codes_due.pop_front();
                    if (i_m_tdata !== want.code)
                        report($sformatf("code %h, expected %h", i_m_tdata, want.code));
                    if (i_m_tuser[0] !== want.final_flag)
                        report($sformatf("final flag %b, expected %b on code %h",
                                         i_m_tuser[0], want.final_flag, want.code));
                end
            end
            if (i_s_tvalid && i_s_tready)
                compress_byte(i_s_tdata, i_s_tlast);
        end
    end

endmodule

/* bench/lzw_hashed_dictionary_compressor_test.sv */
// ----------------------------------------------------------------------------
// LZW compressor testbench
// Feeds directed and random byte streams, each closed by a final byte, with
// random gaps and stalls, bar the last; the scoreboard checks every code.
// ----------------------------------------------------------------------------
module lzw_hashed_dictionary_compressor_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    int fail_count;
    int codes_pending;
    int codes_seen;
    int bytes_sent;
    int streams_sent;
    bit quiet;
    bit long_hold;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lzw_hashed_dictionary_compressor dut (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tlast,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser
    );

    lzw_dictionary_scoreboard scoreboard (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tlast,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata),
        .i_m_tuser(o_m_tuser),
        .o_fail_count(fail_count), .o_codes_pending(codes_pending),
        .o_codes_seen(codes_seen)
    );

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                i_m_tready <= 1'b0;
                repeat (800) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(19, 1)) @(negedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (!quiet && $urandom_range(4) == 0) begin
            gap = $urandom_range(19, 1);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
        if (last) streams_sent++;
    endtask

    // Random stream over a mostly small alphabet: strings repeat and chains grow.
    task automatic send_stream(int len, bit hold_mid);
        int span;
        logic [7:0] base;
        logic [7:0] b;
        case ($urandom_range(5))
            0: span = 1;
            1: span = 2;
            2: span = 3;
            3: span = 4;
            4: span = 16;
            default: span = 256;
        endcase
        base = 8'($urandom_range(255));
        for (int i = 0; i < len; i++) begin
            if (hold_mid && i == len / 3) long_hold = 1'b1;
            if ($urandom_range(19) == 0) b = 8'($urandom_range(255));
            else b = base + 8'($urandom_range(span - 1));
            send_byte(b, i == len - 1);
        end
    endtask

    initial begin
        logic [7:0] directed [$];
        quiet = 1'b0;
        long_hold = 1'b0;
        bytes_sent = 0;
        streams_sent = 0;
        directed = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                     8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h01, 8'h02,
                     8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h7F};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_byte(directed[i], i == directed.size() - 1);
        // A stream of one byte that is also the final one.
        send_byte(8'h33, 1'b1);
        // Sender pauses until every code has come out.
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (codes_pending == 0);
        send_stream(380, 1'b1);
        send_stream(340, 1'b0);
        send_stream(340, 1'b0);
        quiet = 1'b1;
        send_stream(360, 1'b0);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        wait (codes_pending == 0);
        repeat (200) @(posedge i_clk);
        $display("Run covered %0d streams, %0d bytes and %0d codes.",
                 streams_sent, bytes_sent, codes_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("Timeout with %0d codes outstanding.", codes_pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
